[sv/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window package
// Shared constants and the command and status types between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package srrw_pkg;

   localparam int unsigned SEQ_BITS = 3;

   typedef struct packed {
      logic capture;
      logic classify;
      logic load_ack;
      logic load_deliver;
   } srrw_cmd_type;

   typedef struct packed {
      logic has_ack;
      logic deliver_start;
      logic out_free;
      logic next_filled;
   } srrw_status_type;

endpackage

[sv/srrw_ctrl.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window controller
// Sequences capture, classification, the acknowledgement and the in-order
// deliveries of one packet, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module srrw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  srrw_pkg::srrw_status_type status,
   output srrw_pkg::srrw_cmd_type    cmd
);
   import srrw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_CLASSIFY = 4'b0010,
      ST_ACK      = 4'b0100,
      ST_DELIVER  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            state_in     = status.has_ack ? ST_ACK : ST_IDLE;
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = status.deliver_start ? ST_DELIVER : ST_IDLE;
            end
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.load_deliver = 1'b1;
               if (!status.next_filled) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/srrw_datapath.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window datapath
// Holds the window base, the slot buffer with its filled bits, the captured
// packet and the output register.
// ----------------------------------------------------------------------------
module srrw_datapath #(
   parameter int unsigned WINDOW       = 4,
   parameter int unsigned SEQ_SPACE    = 8,
   parameter int unsigned PAYLOAD_BITS = 64,
   parameter int unsigned IN_DW        = 72,
   parameter int unsigned OUT_DW       = 72
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IN_DW-1:0]          req_tdata,
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_DW-1:0]         rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast,
   input  srrw_pkg::srrw_cmd_type    cmd,
   output srrw_pkg::srrw_status_type status
);
   import srrw_pkg::*;

   localparam int unsigned BASE_W = $clog2(SEQ_SPACE);
   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned RED_W  = ((BASE_W > SEQ_BITS) ? BASE_W : SEQ_BITS) + 1;
   localparam int unsigned DW     = BASE_W + 1;
   localparam int unsigned IW     = ((BASE_W > SLOT_W) ? BASE_W : SLOT_W) + 1;
   localparam int unsigned HW     = SLOT_W + 1;
   localparam int unsigned RED_STEPS = (1 << SEQ_BITS) / 2;

   logic [SEQ_BITS-1:0]     seq_ff;
   logic [PAYLOAD_BITS-1:0] payload_ff;
   logic                    ok_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [BASE_W-1:0]       base_in;
   logic [SLOT_W-1:0]       head_ff;
   logic [SLOT_W-1:0]       head_in;
   logic [WINDOW-1:0]       filled_ff;
   logic [WINDOW-1:0]       filled_in;
   logic [PAYLOAD_BITS-1:0] slot_ff [WINDOW];

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_kind_ff;
   logic [SEQ_BITS-1:0]     rsp_ack_ff;
   logic [PAYLOAD_BITS-1:0] rsp_payload_ff;
   logic                    rsp_last_ff;

   logic [RED_W-1:0]        red_tmp;
   logic [BASE_W-1:0]       seq_red;
   logic [DW-1:0]           dsum;
   logic [BASE_W-1:0]       seq_offset;
   logic                    in_cur;
   logic                    in_prev;
   logic [IW-1:0]           isum;
   logic [SLOT_W-1:0]       slot_idx;
   logic [HW-1:0]           hsum;
   logic [SLOT_W-1:0]       head_next;
   logic [DW-1:0]           bsum;
   logic                    write_en;

   always_comb begin
      red_tmp = RED_W'(seq_ff);
      for (int k = 0; k < RED_STEPS; k++) begin
         if (red_tmp >= RED_W'(SEQ_SPACE)) begin
            red_tmp = red_tmp - RED_W'(SEQ_SPACE);
         end
      end
      seq_red = BASE_W'(red_tmp);
   end

   always_comb begin
      dsum = DW'(seq_red) + DW'(SEQ_SPACE) - DW'(base_ff);
      if (dsum >= DW'(SEQ_SPACE)) begin
         dsum = dsum - DW'(SEQ_SPACE);
      end
      seq_offset = BASE_W'(dsum);
      in_cur     = 32'(seq_offset) < WINDOW;
      in_prev    = !in_cur && ((32'(seq_offset) + WINDOW) >= SEQ_SPACE);

      isum = IW'(head_ff) + IW'(seq_offset);
      if (isum >= IW'(WINDOW)) begin
         isum = isum - IW'(WINDOW);
      end
      slot_idx = SLOT_W'(isum);

      hsum = HW'(head_ff) + HW'(1);
      if (hsum >= HW'(WINDOW)) begin
         hsum = '0;
      end
      head_next = SLOT_W'(hsum);

      bsum = DW'(base_ff) + DW'(1);
      if (bsum >= DW'(SEQ_SPACE)) begin
         bsum = '0;
      end
   end

   assign write_en = cmd.classify && ok_ff && in_cur && !filled_ff[slot_idx];

   assign status.has_ack       = ok_ff && (in_cur || in_prev);
   assign status.deliver_start = ok_ff && in_cur && (seq_offset == '0);
   assign status.out_free      = !rsp_valid_ff || rsp_tready;
   assign status.next_filled   = filled_ff[head_next] && (head_next != head_ff);

   always_comb begin
      filled_in = filled_ff;
      base_in   = base_ff;
      head_in   = head_ff;
      if (write_en) begin
         filled_in[slot_idx] = 1'b1;
      end
      if (cmd.load_deliver) begin
         filled_in[head_ff] = 1'b0;
         head_in            = head_next;
         base_in            = BASE_W'(bsum);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_ack || cmd.load_deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         head_ff      <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         head_ff      <= head_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ok_ff      <= req_tuser;
         seq_ff     <= req_tdata[SEQ_BITS-1:0];
         payload_ff <= req_tdata[SEQ_BITS +: PAYLOAD_BITS];
      end
      if (write_en) begin
         slot_ff[slot_idx] <= payload_ff;
      end
      if (cmd.load_ack) begin
         rsp_kind_ff    <= 1'b0;
         rsp_ack_ff     <= SEQ_BITS'(seq_red);
         rsp_payload_ff <= '0;
         rsp_last_ff    <= !status.deliver_start;
      end else if (cmd.load_deliver) begin
         rsp_kind_ff    <= 1'b1;
         rsp_ack_ff     <= '0;
         rsp_payload_ff <= slot_ff[head_ff];
         rsp_last_ff    <= !status.next_filled;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_payload_ff, rsp_ack_ff});
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[sv/selective_repeat_receive_window.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window
// Receiver side of selective-repeat ARQ: acknowledges, buffers and delivers
// data packets in sequence order.
// ----------------------------------------------------------------------------
// A packet is classified in the cycle after it is taken. A packet with a bad
// checksum, or one outside both the current and the previous window, ends
// there and produces no transaction. Otherwise the acknowledgement follows,
// and when the packet carries the window base the buffered payloads are
// delivered in order behind it, one transaction per cycle while the output
// is not stalled, through a single output register. The input is ready again
// as soon as the last result is loaded into the output register, even if it
// is not yet taken. After reset the block is ready at once.
module selective_repeat_receive_window #(
   parameter int unsigned WINDOW       = 4,
   parameter int unsigned SEQ_SPACE    = 8,
   parameter int unsigned PAYLOAD_BITS = 64
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // Fields from bit 0: seq_number, payload, zero fill.
   input  logic [((srrw_pkg::SEQ_BITS+PAYLOAD_BITS+7)/8)*8-1:0] req_tdata,
   // Fields: checksum_ok.
   input  logic                                          req_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // Fields from bit 0: ack_number, delivered_payload, zero fill.
   output logic [((srrw_pkg::SEQ_BITS+PAYLOAD_BITS+7)/8)*8-1:0] rsp_tdata,
   // Fields: kind.
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast
);
   import srrw_pkg::*;

   localparam int unsigned DATA_W = ((SEQ_BITS + PAYLOAD_BITS + 7) / 8) * 8;

   srrw_cmd_type    cmd;
   srrw_status_type status;

   srrw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srrw_datapath #(
      .WINDOW       (WINDOW),
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .IN_DW        (DATA_W),
      .OUT_DW       (DATA_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[sv/srrw_checker.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window checker
// Port-level properties of the receive window, attached to the top level.
// ----------------------------------------------------------------------------
module srrw_checker #(
   parameter int unsigned PAYLOAD_BITS = 64
) (
   input logic                                                 clock,
   input logic                                                 reset,
   input logic                                                 req_tvalid,
   input logic                                                 req_tready,
   input logic                                                 rsp_tvalid,
   input logic                                                 rsp_tready,
   input logic [((srrw_pkg::SEQ_BITS+PAYLOAD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                                                 rsp_tuser,
   input logic                                                 rsp_tlast
);
   import srrw_pkg::*;

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready
   ) else $error("Input still ready in the cycle after a packet was taken.");

   a_ack_no_payload: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[SEQ_BITS +: PAYLOAD_BITS] == '0)
   ) else $error("Acknowledgement carries a nonzero payload.");

   a_delivery_no_ack: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[SEQ_BITS-1:0] == '0)
   ) else $error("Delivery carries a nonzero acknowledgement number.");

   a_ack_not_after_delivery: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast)
         |=> !(rsp_tvalid && !rsp_tuser)
   ) else $error("Acknowledgement follows an unfinished delivery run.");

   a_stall_holds: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
   ) else $error("Stalled result transaction changed.");

endmodule

bind selective_repeat_receive_window srrw_checker #(
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srrw_checker (.*);

[tb/selective_repeat_receive_window_tb.sv]
// ----------------------------------------------------------------------------
// Selective-repeat receive window testbench
// Sends data packets to the receive window, with directed cases first and
// random traffic after. A scoreboard predicts the acknowledgements and the
// in-order deliveries and compares every result transaction against them.
// Both stream sides insert random idle cycles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selective_repeat_receive_window_tb;

   import srrw_pkg::*;

   localparam int unsigned WINDOW       = 4;
   localparam int unsigned SEQ_SPACE    = 8;
   localparam int unsigned PAYLOAD_BITS = 64;
   localparam int unsigned DATA_BITS    = ((SEQ_BITS + PAYLOAD_BITS + 7) / 8) * 8;
   localparam int unsigned RANDOM_PACKETS = 320;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 3 + WINDOW + 16;
   localparam int unsigned MAX_REPORTS  = 10;

   typedef logic [SEQ_BITS-1:0]     seq_type;
   typedef logic [PAYLOAD_BITS-1:0] payload_type;

   typedef struct {
      bit          kind;
      seq_type     ack_number;
      payload_type data;
      bit          last;
   } window_result_type;

   class receive_window_scoreboard;
      window_result_type expected_results[$];
      seq_type           window_base;
      bit                slot_filled[WINDOW];
      payload_type       slot_payload[WINDOW];
      int                mismatches;
      int                packets_seen;
      int                packets_dropped;
      int                acks_predicted;
      int                deliveries_predicted;

      function new();
         window_base = '0;
         foreach (slot_filled[i]) begin
            slot_filled[i]  = 1'b0;
            slot_payload[i] = '0;
         end
      endfunction

      function void add_expected(window_result_type entry);
         expected_results = {expected_results, entry};
      endfunction

      function void predict_packet(bit checksum_ok, seq_type seq, payload_type payload);
         window_result_type item;
         int unsigned       offset;
         int unsigned       run;
         bit                in_current;
         bit                in_previous;
         packets_seen++;
         if (!checksum_ok) begin
            packets_dropped++;
            return;
         end
         offset      = (int'(seq) + SEQ_SPACE - int'(window_base)) % SEQ_SPACE;
         in_current  = offset < WINDOW;
         in_previous = !in_current && (offset + WINDOW >= SEQ_SPACE);
         if (in_current && !slot_filled[offset]) begin
            slot_filled[offset]  = 1'b1;
            slot_payload[offset] = payload;
         end
         run = 0;
         if (in_current && offset == 0) begin
            while (run < WINDOW && slot_filled[run]) run++;
         end
         if (in_current || in_previous) begin
            item.kind       = 1'b0;
            item.ack_number = seq;
            item.data       = '0;
            item.last       = (run == 0);
            add_expected(item);
            acks_predicted++;
         end
         for (int k = 0; k < run; k++) begin
            item.kind       = 1'b1;
            item.ack_number = '0;
            item.data       = slot_payload[0];
            item.last       = (k == run - 1);
            add_expected(item);
            deliveries_predicted++;
            for (int i = 0; i + 1 < WINDOW; i++) begin
               slot_filled[i]  = slot_filled[i + 1];
               slot_payload[i] = slot_payload[i + 1];
            end
            slot_filled[WINDOW - 1]  = 1'b0;
            slot_payload[WINDOW - 1] = '0;
            window_base = seq_type'((int'(window_base) + 1) % SEQ_SPACE);
         end
      endfunction

      function void note_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("tb: mismatch: %s", msg);
      endfunction

      function void check_result(logic kind, seq_type ack_number, payload_type data,
                                 logic last);
         window_result_type exp_item;
         if (expected_results.size() == 0) begin
            note_mismatch($sformatf("unexpected transaction kind=%0d ack=%0d data=%h last=%0d",
                                    kind, ack_number, data, last));
            return;
         end
         exp_item = expected_results.pop_front();
         if (exp_item.kind !== kind || exp_item.ack_number !== ack_number ||
             exp_item.data !== data || exp_item.last !== last) begin
            note_mismatch($sformatf(
               "expected kind=%0d ack=%0d data=%h last=%0d, got kind=%0d ack=%0d data=%h last=%0d",
               exp_item.kind, exp_item.ack_number, exp_item.data, exp_item.last,
               kind, ack_number, data, last));
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;

   receive_window_scoreboard sb = new();

   bit          no_idle = 1'b0;
   int          rsp_stall_left = 0;
   int unsigned cycle_count = 0;

   selective_repeat_receive_window #(
      .WINDOW       (WINDOW),
      .SEQ_SPACE    (SEQ_SPACE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_idle();
      return no_idle ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic payload_type random_payload();
      payload_type value;
      value = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: value = '0;
         1: value = '1;
         default: ;
      endcase
      return value;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b1;
         rsp_stall_left = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata[SEQ_BITS-1:0],
                         rsp_tdata[SEQ_BITS+PAYLOAD_BITS-1:SEQ_BITS], rsp_tlast);
         rsp_stall_left = draw_idle();
         if (rsp_stall_left > 0) rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rsp_stall_left > 0) rsp_stall_left = rsp_stall_left - 1;
         if (rsp_stall_left == 0) rsp_tready <= 1'b1;
      end
   end

   task automatic send_packet(input bit checksum_ok, input seq_type seq,
                              input payload_type payload);
      int gap;
      gap = draw_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= checksum_ok;
      req_tdata  <= DATA_BITS'({payload, seq});
      do @(posedge clock); while (!req_tready);
      sb.predict_packet(checksum_ok, seq, payload);
   endtask

   task automatic send_random_packet();
      int      pick;
      seq_type seq;
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
         seq = sb.window_base + seq_type'($urandom_range(0, WINDOW - 1));
         send_packet(1'b1, seq, random_payload());
      end else if (pick < 88) begin
         seq = sb.window_base - seq_type'($urandom_range(1, WINDOW));
         send_packet(1'b1, seq, random_payload());
      end else begin
         send_packet(1'($urandom_range(0, 1)), seq_type'($urandom), random_payload());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: drops, out-of-order fill, duplicates, previous window,
      // a full window delivery and a wrap of the sequence space.
      send_packet(1'b0, 3'd0, '1);
      send_packet(1'b1, 3'd3, '1);
      send_packet(1'b1, 3'd1, '0);
      send_packet(1'b1, 3'd2, 64'ha5a5_5a5a_f00f_0ff0);
      send_packet(1'b1, 3'd1, 64'hdead_beef_0000_0001);
      send_packet(1'b1, 3'd6, 64'h1234_5678_9abc_def0);
      send_packet(1'b1, 3'd4, '1);
      send_packet(1'b1, 3'd0, 64'h0000_0000_0000_0001);
      send_packet(1'b1, 3'd7, 64'h8000_0000_0000_0000);
      send_packet(1'b1, 3'd5, '0);
      send_packet(1'b1, 3'd3, 64'h5555_5555_5555_5555);
      send_packet(1'b1, 3'd6, 64'haaaa_aaaa_aaaa_aaaa);
      send_packet(1'b1, 3'd4, '1);
      send_packet(1'b1, 3'd5, 64'h0123_4567_89ab_cdef);
      send_packet(1'b0, 3'd7, '1);
      send_packet(1'b1, 3'd0, '1);
      send_packet(1'b1, 3'd2, 64'hfedc_ba98_7654_3210);
      send_packet(1'b1, 3'd1, '1);
      send_packet(1'b0, 3'd1, '0);

      for (int n = 0; n < RANDOM_PACKETS; n++) begin
         if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_random_packet();
      end
      no_idle = 1'b0;

      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d packets sent, %0d dropped for bad checksum",
               sb.packets_seen, sb.packets_dropped);
      $display("tb: %0d acknowledgements and %0d deliveries checked, %0d mismatches",
               sb.acks_predicted, sb.deliveries_predicted, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
sv/srrw_pkg.sv
sv/srrw_ctrl.sv
sv/srrw_datapath.sv
sv/selective_repeat_receive_window.sv
sv/srrw_checker.sv
tb/selective_repeat_receive_window_tb.sv
